/* hdl/mtvl_pkg.sv */
// Package for the masked trilinear vector lookup: constants, register
// indexes, controller state type. No dependencies.
package mtvl_pkg;

  localparam int unsigned DEF_GRID_X = 32;
  localparam int unsigned DEF_GRID_Y = 32;
  localparam int unsigned DEF_GRID_Z = 32;

  localparam int unsigned ADDR_W = 15;
  localparam int unsigned VEC_W = 16;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INV_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INV_Y = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_INV_Z = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_VMASK = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_BMASK = 3'd7;

  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAP,
    ST_CHECK,
    ST_CORNER,
    ST_DRAIN,
    ST_ROUND,
    ST_OUT
  } ctl_state_t;

endpackage

/* hdl/mtvl_axis_map.sv */
// One axis of the coordinate mapper: origin subtract, multiply by inverse
// spacing, range check, base index and fraction. Uses mtvl_pkg.
module mtvl_axis_map #(
  parameter int unsigned N = 32
) (
  input  logic              clk,
  input  logic              start,
  input  logic signed [31:0] q,
  input  logic signed [31:0] org,
  input  logic [31:0]       inv,
  output logic              in_grid,
  output logic [7:0]        base,
  output logic [16:0]       frac
);
  import mtvl_pkg::*;

  localparam logic [7:0] LAST_BASE = 8'(N - 2);

  logic signed [32:0] d;
  logic               neg_r;
  logic [31:0]        dmag_r;
  logic [63:0]        f;
  logic [47:0]        coord;
  logic [31:0]        ip;
  logic               over;

  assign d = 33'(q) - 33'(org);

  // Stage 1: register the difference.
  always_ff @(posedge clk) begin
    if (start) begin
      neg_r <= d[32];
      dmag_r <= d[31:0];
    end
  end

  assign f = 64'(dmag_r) * 64'(inv);
  assign over = f > (64'(N - 1) << 32);
  assign coord = f[63:16];
  assign ip = coord[47:16] > 32'(LAST_BASE) ? 32'(LAST_BASE) : coord[47:16];
  assign in_grid = !neg_r && !over;
  assign base = ip[7:0];
  assign frac = 17'(coord - (48'(ip) << 16));
endmodule

/* hdl/mtvl_accum.sv */
// Weight and accumulate unit: corner weight, masked weighted sum, floor and
// saturation to Q8.8. Uses mtvl_pkg.
module mtvl_accum (
  input  logic              clk,
  input  logic              clr,
  input  logic              wt_en,
  input  logic [16:0]       fx,
  input  logic [16:0]       fy,
  input  logic [16:0]       fz,
  input  logic              acc_en,
  input  logic              skip,
  input  logic [47:0]       vec,
  output logic signed [15:0] res_x,
  output logic signed [15:0] res_y,
  output logic signed [15:0] res_z
);
  import mtvl_pkg::*;

  logic [33:0]        pxy;
  logic [16:0]        pxy_r;
  logic [16:0]        fz_r;
  logic [33:0]        w_full;
  logic [16:0]        w_r;
  logic signed [53:0] ax_r, ay_r, az_r;

  assign pxy = 34'(fx) * 34'(fy);

  // Weight pipeline: one product per cycle.
  always_ff @(posedge clk) begin
    pxy_r <= pxy[32:16];
    fz_r <= fz;
  end
  assign w_full = 34'(pxy_r) * 34'(fz_r);
  always_ff @(posedge clk) begin
    if (wt_en) w_r <= w_full[32:16];
  end

  function automatic logic signed [53:0] wmul(input logic [16:0] w,
                                              input logic [15:0] v);
    logic signed [34:0] p;
    p = $signed({1'b0, w}) * $signed(v);
    return 54'(p);
  endfunction

  always_ff @(posedge clk) begin
    if (clr) begin
      ax_r <= '0;
      ay_r <= '0;
      az_r <= '0;
    end else if (acc_en && !skip) begin
      ax_r <= ax_r + wmul(w_r, vec[15:0]);
      ay_r <= ay_r + wmul(w_r, vec[31:16]);
      az_r <= az_r + wmul(w_r, vec[47:32]);
    end
  end

  function automatic logic signed [15:0] sat(input logic signed [53:0] s);
    logic signed [37:0] r;
    r = 38'(s >>> 16);
    if (r > 38'sd32767) return 16'sh7fff;
    if (r < -38'sd32768) return 16'sh8000;
    return r[15:0];
  endfunction

  assign res_x = sat(ax_r);
  assign res_y = sat(ay_r);
  assign res_z = sat(az_r);
endmodule

/* hdl/masked_trilinear_vector_lookup.sv */
// Top level of the masked trilinear vector lookup.
// Depends on mtvl_pkg, mtvl_axis_map and mtvl_accum.
//
// Grid memory of 50-bit words (vector plus valid and inside flags), one
// synchronous port with a registered read. A write word is stored as it is taken.
// A query word holds the input until it is through: it registers the origin
// offsets, does the multiply, range check and base and fraction capture, makes
// eight corner reads (the single memory port reads one corner per cycle),
// drains the weight and accumulate pipeline, rounds and loads the output
// register; the result shows the cycle after the load. A point outside the grid
// reads no corners. Results sit in an output register; a new input word is taken
// while a result waits there, and a query that finishes meanwhile holds until
// the register frees up. Grid entries must be written before read; there is no
// clear pass after reset.
module masked_trilinear_vector_lookup
  import mtvl_pkg::*;
#(
  parameter int unsigned GRID_X = DEF_GRID_X,
  parameter int unsigned GRID_Y = DEF_GRID_Y,
  parameter int unsigned GRID_Z = DEF_GRID_Z
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_mode,
  input  logic [14:0]          in_entry_index,
  input  logic signed [15:0]   in_entry_vx,
  input  logic signed [15:0]   in_entry_vy,
  input  logic signed [15:0]   in_entry_vz,
  input  logic                 in_entry_valid,
  input  logic                 in_entry_inside,
  input  logic signed [31:0]   in_query_x,
  input  logic signed [31:0]   in_query_y,
  input  logic signed [31:0]   in_query_z,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic signed [15:0]   out_wind_x,
  output logic signed [15:0]   out_wind_y,
  output logic signed [15:0]   out_wind_z,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [2:0]           cfg_index,
  input  logic [31:0]          cfg_data
);
  // config registers
  logic signed [31:0] org_x_r, org_y_r, org_z_r;
  logic [31:0]        inv_x_r, inv_y_r, inv_z_r;
  logic               vmask_r, bmask_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      org_x_r <= '0;
      org_y_r <= '0;
      org_z_r <= '0;
      inv_x_r <= 32'd65536;
      inv_y_r <= 32'd65536;
      inv_z_r <= 32'd65536;
      vmask_r <= 1'b0;
      bmask_r <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_ORIGIN_X: org_x_r <= cfg_data;
        REG_ORIGIN_Y: org_y_r <= cfg_data;
        REG_ORIGIN_Z: org_z_r <= cfg_data;
        REG_INV_X:    inv_x_r <= cfg_data;
        REG_INV_Y:    inv_y_r <= cfg_data;
        REG_INV_Z:    inv_z_r <= cfg_data;
        REG_VMASK:    vmask_r <= cfg_data[0];
        REG_BMASK:    bmask_r <= cfg_data[0];
        default:      ;
      endcase
    end
  end

  // control
  ctl_state_t state_r, state_nxt;
  logic [3:0] cnt_r, cnt_nxt;
  logic       in_acc;
  logic       out_full_r;
  logic       out_load;
  logic       inside_all_r;

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc = in_valid && !in_stall;
  // result moves into the output register once it is free or being drained
  assign out_load = (state_r == ST_OUT) && (!out_full_r || !out_stall);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    case (state_r)
      ST_IDLE: if (in_acc && in_mode == MODE_QUERY) state_nxt = ST_MAP;
      ST_MAP: state_nxt = ST_CHECK;
      ST_CHECK: begin
        cnt_nxt = '0;
        state_nxt = ST_CORNER;
      end
      ST_CORNER: begin
        cnt_nxt = cnt_r + 4'd1;
        if (cnt_r == 4'd7 || !inside_all_r) begin
          cnt_nxt = '0;
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        cnt_nxt = cnt_r + 4'd1;
        if (cnt_r == 4'd2) state_nxt = ST_ROUND;
      end
      ST_ROUND: state_nxt = ST_OUT;
      ST_OUT: if (out_load) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // query latch and mapping
  logic signed [31:0] qx_r, qy_r, qz_r;
  logic in_x, in_y, in_z;
  logic [7:0] bx, by, bz;
  logic [16:0] tx, ty, tz;
  logic [7:0] bx_r, by_r, bz_r;
  logic [16:0] tx_r, ty_r, tz_r;
  logic map_start;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      qx_r <= in_query_x;
      qy_r <= in_query_y;
      qz_r <= in_query_z;
    end
  end
  assign map_start = (state_r == ST_MAP);

  mtvl_axis_map #(.N(GRID_X)) u_mx (.clk, .start(map_start), .q(qx_r),
    .org(org_x_r), .inv(inv_x_r), .in_grid(in_x), .base(bx), .frac(tx));
  mtvl_axis_map #(.N(GRID_Y)) u_my (.clk, .start(map_start), .q(qy_r),
    .org(org_y_r), .inv(inv_y_r), .in_grid(in_y), .base(by), .frac(ty));
  mtvl_axis_map #(.N(GRID_Z)) u_mz (.clk, .start(map_start), .q(qz_r),
    .org(org_z_r), .inv(inv_z_r), .in_grid(in_z), .base(bz), .frac(tz));

  always_ff @(posedge clk) begin
    if (state_r == ST_CHECK) begin
      inside_all_r <= in_x && in_y && in_z;
      bx_r <= bx;
      by_r <= by;
      bz_r <= bz;
      tx_r <= tx;
      ty_r <= ty;
      tz_r <= tz;
    end
  end

  // corner address and factors; corner bits are dx, dy, dz from msb
  logic [2:0]  cor;
  logic [31:0] lin;
  logic [16:0] fx, fy, fz;
  assign cor = cnt_r[2:0];
  assign lin = 32'(bx_r + 8'(cor[2])) + 32'(GRID_X) * (32'(by_r + 8'(cor[1]))
             + 32'(GRID_Y) * 32'(bz_r + 8'(cor[0])));
  assign fx = cor[2] ? tx_r : 17'd65536 - tx_r;
  assign fy = cor[1] ? ty_r : 17'd65536 - ty_r;
  assign fz = cor[0] ? tz_r : 17'd65536 - tz_r;

  // grid memory: {inside, valid, vz, vy, vx}
  logic [49:0] mem [0:(1 << ADDR_W) - 1];
  logic [49:0] rd_r;
  logic        do_rd, wr_en;
  logic [14:0] mem_addr;

  assign wr_en = in_acc && in_mode == MODE_WRITE;
  assign do_rd = (state_r == ST_CORNER) && inside_all_r;
  assign mem_addr = wr_en ? in_entry_index : lin[ADDR_W-1:0];

  always_ff @(posedge clk) begin
    if (wr_en)
      mem[mem_addr] <= {in_entry_inside, in_entry_valid, in_entry_vz, in_entry_vy,
                        in_entry_vx};
    rd_r <= mem[mem_addr];
  end

  // pipeline alignment: factors enter in the corner state and reach the weight
  // through pxy_r and w_r, memory data only through rd_r -> delay read data in rd2_r
  logic        v1_r, v2_r;
  logic [49:0] rd2_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= do_rd;
      v2_r <= v1_r;
    end
    rd2_r <= rd_r;
  end

  logic skip;
  assign skip = (vmask_r && !rd2_r[48]) || (bmask_r && rd2_r[49]);

  logic signed [15:0] rx, ry, rz;
  mtvl_accum u_acc (
    .clk, .clr(state_r == ST_CHECK), .wt_en(v1_r), .fx, .fy, .fz,
    .acc_en(v2_r), .skip, .vec(rd2_r[47:0]),
    .res_x(rx), .res_y(ry), .res_z(rz));

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) out_full_r <= 1'b0;
    else if (out_load) out_full_r <= 1'b1;
    else if (!out_stall) out_full_r <= 1'b0;
  end
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_wind_x <= rx;
      out_wind_y <= ry;
      out_wind_z <= rz;
    end
  end
  assign out_valid = out_full_r;
endmodule

/* hdl/mtvl_checker.sv */
// Port-level checker for the masked trilinear vector lookup, with bind.
// Uses only top-level ports.
module mtvl_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_stall,
  input logic in_mode,
  input logic out_valid,
  input logic out_stall,
  input logic [15:0] out_wind_x
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_wind_x))
    else $error("result dropped while stalled");
  a_write_no_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && !in_mode && !out_valid |=> !out_valid)
    else $error("write produced a result");
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_mode |=> in_stall)
    else $error("query not interlocked");
  a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_mode |=> ##1 !$rose(out_valid))
    else $error("result too early");
endmodule

bind masked_trilinear_vector_lookup mtvl_checker u_chk (
  .clk, .rst_n, .in_valid, .in_stall, .in_mode, .out_valid, .out_stall,
  .out_wind_x);
